// ===== rtl/core/ahs_pkg.sv =====
// ----------------------------------------------------------------------------
// ahs_pkg: shared constants and the quarter-wave sine table
// Fixed sine table geometry and the table itself, built at elaboration from a
// Q30 Taylor series and rounded to Q1.15.
// ----------------------------------------------------------------------------
package ahs_pkg;

	localparam int SINE_TABLE_BITS = 10;
	localparam int QUARTER_BITS    = SINE_TABLE_BITS - 2;
	localparam int QUARTER_SIZE    = 1 << QUARTER_BITS;
	// table address reaches QUARTER_SIZE itself
	localparam int QA_W            = QUARTER_BITS + 1;
	localparam int MAG_W           = 15;

	localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

	typedef logic [QUARTER_SIZE:0][MAG_W-1:0] qtab_t;

	// sin(pi/2 * i / QUARTER_SIZE), Q1.15, rounded half up, capped at 32767
	function automatic qtab_t build_qtab();
		qtab_t       t;
		logic [63:0] x;
		logic [63:0] x2;
		logic [63:0] term;
		logic [63:0] sum;
		logic [63:0] prod;
		logic [63:0] r;
		t = '0;
		for (int i = 0; i <= QUARTER_SIZE; i++) begin
			x    = (HALF_PI_Q30 * 64'(i)) >> QUARTER_BITS;
			x2   = (x * x) >> 30;
			term = x;
			sum  = x;
			for (int n = 1; n <= 6; n++) begin
				prod = (term * x2) >> 30;
				unique case (n)
					1: term = prod / 64'd6;
					2: term = prod / 64'd20;
					3: term = prod / 64'd42;
					4: term = prod / 64'd72;
					5: term = prod / 64'd110;
					default: term = prod / 64'd156;
				endcase
				if ((n % 2) == 1) begin
					sum = sum - term;
				end else begin
					sum = sum + term;
				end
			end
			r = (sum + 64'd16384) >> 15;
			if (r > 64'd32767) begin
				r = 64'd32767;
			end
			t[i] = r[MAG_W-1:0];
		end
		return t;
	endfunction

	localparam qtab_t QTAB = build_qtab();

endpackage

// ===== rtl/core/ahs_div.sv =====
// ----------------------------------------------------------------------------
// ahs_div: unsigned divider by a constant
// Reciprocal multiplication into a registered quotient; done pulses the cycle
// after start with the quotient valid.
// ----------------------------------------------------------------------------
module ahs_div #(
	parameter int DIV_W   = 21,
	parameter int DIVISOR = 10
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [DIV_W-1:0] dividend,
	output logic             done,
	output logic [DIV_W-1:0] quotient
);

	// quotient = (dividend * ceil(2^SH / DIVISOR)) >> SH, exact for every
	// dividend below 2^DIV_W
	localparam int              SH      = DIV_W + $clog2(DIVISOR);
	localparam int              M_W     = DIV_W + 2;
	localparam int              P_W     = DIV_W + M_W;
	localparam longint unsigned RECIP   =
		((64'd1 << SH) + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR);
	localparam logic [M_W-1:0]  RECIP_M = M_W'(RECIP);

	logic [P_W-1:0]   prod;
	logic             done_q;
	logic [DIV_W-1:0] quo_q;

	assign prod = {{M_W{1'b0}}, dividend} * {{DIV_W{1'b0}}, RECIP_M};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= start;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= DIV_W'(prod[P_W-1:SH]);
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

// ===== rtl/core/additive_harmonic_synth.sv =====
// ----------------------------------------------------------------------------
// additive_harmonic_synth: harmonic oscillator bank with a mixed output
// Each tick beat with tick set yields one Q1.15 sample: the mean of HARMONICS weighted sines.
// ----------------------------------------------------------------------------
// A tick beat with tick set starts one sample. The block then walks the
// harmonics one per cycle through a single phase adder and sine lookup,
// drains the lookup stage, loads the mean, runs a registered reciprocal
// multiply that divides the sum by HARMONICS, and moves the sample into the
// output register. s_axis_tready is high only while the block is idle, so a
// tick is not taken until the sample before it has reached the output
// register. A finished sample waits in the output register, so the next tick
// is taken while it is still unread; a second finished sample then waits in
// the block until the output register frees up. A tick beat with tick clear
// is taken and ignored.
// Harmonic k (1 based) advances by k * phase_step each sample, modulo 2^32,
// and is weighted by 2^-(gain_decay_shift * (k - 1)). The sample uses the
// phases from before the tick. Configuration writes go through cfg_we,
// cfg_index and cfg_data and are meant to happen while the block is idle.
// ----------------------------------------------------------------------------
module additive_harmonic_synth #(
	parameter int HARMONICS = 10
) (
	input  logic        clk,
	input  logic        arst_n,
	// input stream
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [0] tick, [7:1] zero
	// output stream
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [15:0] m_axis_tdata,   // [15:0] sample (signed q1.15)
	// configuration write port
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [31:0] cfg_data
);

	import ahs_pkg::*;

	localparam int IDX_W = (HARMONICS > 1) ? $clog2(HARMONICS) : 1;
	localparam int SUM_W = 17 + $clog2(HARMONICS);

	// register indexes
	localparam logic REG_PHASE_STEP = 1'b0;
	localparam logic REG_GAIN_DECAY = 1'b1;

	// sequencer states
	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_RUN   = 3'd1;
	localparam logic [2:0] ST_DRAIN = 3'd2;
	localparam logic [2:0] ST_LOAD  = 3'd3;
	localparam logic [2:0] ST_DIV   = 3'd4;
	localparam logic [2:0] ST_DONE  = 3'd5;

	localparam logic [4:0] SHIFT_CAP = 5'd16;

	// configuration
	logic [31:0] phase_step_q;
	logic [3:0]  gain_decay_q;

	// sequencer and harmonic walk
	logic [2:0]                  state_q;
	logic [IDX_W-1:0]            idx_q;
	logic [31:0]                 inc_q;     // (k+1) * phase_step for the current harmonic
	logic [4:0]                  shift_q;   // decay * k, capped at 16
	logic [HARMONICS-1:0][31:0]  phase_q;

	// lookup stage
	logic                        vld_s1;
	logic [MAG_W-1:0]            mag_s1;
	logic                        neg_s1;
	logic [4:0]                  shift_s1;

	// mix and mean
	logic signed [SUM_W-1:0]     sum_q;
	logic                        neg_q;
	logic                        out_vld_q;
	logic [15:0]                 out_data_q;

	logic                        in_beat;
	logic                        out_free;
	logic [31:0]                 phase_rd;
	logic [SINE_TABLE_BITS-1:0]  tab_idx;
	logic [1:0]                  quad;
	logic [QA_W-1:0]             tab_addr;
	logic [5:0]                  shift_sum;
	logic [MAG_W-1:0]            term_mag;
	logic signed [SUM_W-1:0]     term;
	logic [SUM_W-1:0]            sum_abs;
	logic                        div_start;
	logic                        div_done;
	logic [SUM_W-1:0]            quot;
	logic [15:0]                 sample_c;

	assign in_beat  = s_axis_tvalid && s_axis_tready;
	assign out_free = !out_vld_q || m_axis_tready;

	// sine lookup of the current harmonic: mirror in odd quadrants, negate in
	// the lower half cycle
	assign phase_rd = phase_q[idx_q];
	assign tab_idx  = phase_rd[31 -: SINE_TABLE_BITS];
	assign quad     = tab_idx[SINE_TABLE_BITS-1 -: 2];
	assign tab_addr = quad[0] ? QA_W'(QUARTER_SIZE) - {1'b0, tab_idx[QUARTER_BITS-1:0]}
	                          : {1'b0, tab_idx[QUARTER_BITS-1:0]};

	// next harmonic's total gain shift, saturating at "fully attenuated"
	assign shift_sum = {1'b0, shift_q} + {2'b00, gain_decay_q};

	// weighting: magnitude shifted right, sign put back
	assign term_mag = (shift_s1 >= SHIFT_CAP) ? '0 : (mag_s1 >> shift_s1[3:0]);
	assign term     = neg_s1 ? -$signed(SUM_W'(term_mag)) : $signed(SUM_W'(term_mag));

	assign sum_abs   = sum_q[SUM_W-1] ? SUM_W'(-sum_q) : SUM_W'(sum_q);
	assign div_start = (state_q == ST_LOAD);

	// truncated mean of the magnitude, sign restored, clamped to q1.15
	always_comb begin
		if (neg_q) begin
			sample_c = (quot >= SUM_W'(32768)) ? 16'h8000 : (~quot[15:0] + 16'd1);
		end else begin
			sample_c = (quot >= SUM_W'(32767)) ? 16'h7fff : quot[15:0];
		end
	end

	ahs_div #(
		.DIV_W   (SUM_W),
		.DIVISOR (HARMONICS)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (sum_abs),
		.done     (div_done),
		.quotient (quot)
	);

	// configuration registers; an index outside the list is not written
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_step_q <= 32'd42852281;
			gain_decay_q <= 4'd1;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_PHASE_STEP: phase_step_q <= cfg_data;
				REG_GAIN_DECAY: gain_decay_q <= cfg_data[3:0];
				default: ;
			endcase
		end
	end

	// sequencer, phase store and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			idx_q     <= '0;
			phase_q   <= '0;
			vld_s1    <= 1'b0;
			out_vld_q <= 1'b0;
		end else begin
			vld_s1 <= (state_q == ST_RUN);
			if (out_vld_q && m_axis_tready) begin
				out_vld_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					// a beat with tick clear leaves everything as is
					if (in_beat && s_axis_tdata[0]) begin
						idx_q   <= '0;
						state_q <= ST_RUN;
					end
				end
				ST_RUN: begin
					phase_q[idx_q] <= phase_rd + inc_q;
					if (idx_q == IDX_W'(HARMONICS - 1)) begin
						state_q <= ST_DRAIN;
					end else begin
						idx_q <= idx_q + 1'b1;
					end
				end
				ST_DRAIN: state_q <= ST_LOAD;
				ST_LOAD:  state_q <= ST_DIV;
				ST_DIV: begin
					if (div_done) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						out_vld_q <= 1'b1;
						state_q   <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath registers, no reset needed
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE) begin
			inc_q   <= phase_step_q;
			shift_q <= '0;
			sum_q   <= '0;
		end
		if (state_q == ST_RUN) begin
			inc_q   <= inc_q + phase_step_q;
			shift_q <= (shift_sum > 6'(SHIFT_CAP)) ? SHIFT_CAP : shift_sum[4:0];
		end
		mag_s1   <= QTAB[tab_addr];
		neg_s1   <= quad[1];
		shift_s1 <= shift_q;
		if (vld_s1) begin
			sum_q <= sum_q + term;
		end
		if (state_q == ST_LOAD) begin
			neg_q <= sum_q[SUM_W-1];
		end
		if (state_q == ST_DONE && out_free) begin
			out_data_q <= sample_c;
		end
	end

	assign s_axis_tready = (state_q == ST_IDLE);
	assign m_axis_tvalid = out_vld_q;
	assign m_axis_tdata  = out_data_q;

`ifndef NO_ASSERTIONS
	// divider only finishes while the sequencer waits for it
	a_div_done_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (state_q == ST_DIV))
		else $error("divider done outside the divide state");

	// harmonic index stays within the bank while walking
	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RUN) |-> (idx_q <= IDX_W'(HARMONICS - 1)))
		else $error("harmonic index out of range");

	// phases only move while walking the harmonics
	a_phase_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_RUN) |=> $stable(phase_q))
		else $error("phase changed outside the harmonic walk");

	// a finished sample is presented the cycle after it leaves the done state
	a_done_to_out: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE && out_free) |=> m_axis_tvalid)
		else $error("finished sample not presented");

	// lookup stage is valid in the cycle after each walk cycle
	a_s1_follow: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RUN) |=> vld_s1)
		else $error("lookup stage lost a harmonic");
`endif

endmodule
